[rtl/lbs2d_pkg.sv]
package lbs2d_pkg;

  // Bone table geometry
  localparam int MAX_BONES = 64;
  localparam int BONE_AW   = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int BONE_CW   = 11;  // wide enough to compare any bone count in range
  localparam int ROW_W     = 96;  // three 32-bit words per row

  // Item kinds
  localparam logic [1:0] KIND_LOAD       = 2'd0;
  localparam logic [1:0] KIND_WEIGHTED   = 2'd1;
  localparam logic [1:0] KIND_UNWEIGHTED = 2'd2;

  // Transform word selectors
  localparam logic [2:0] COEF_A  = 3'd0;
  localparam logic [2:0] COEF_B  = 3'd1;
  localparam logic [2:0] COEF_C  = 3'd2;
  localparam logic [2:0] COEF_D  = 3'd3;
  localparam logic [2:0] COEF_TX = 3'd4;
  localparam logic [2:0] COEF_TY = 3'd5;

  // Width of intermediate values that get clamped to 32 bits
  localparam int SAT_W = 50;

  // Clamp a wide signed value to the 32-bit signed range
  function automatic logic signed [31:0] sat_to32(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(33'sh0_7FFF_FFFF);
    lo = SAT_W'(33'sh1_8000_0000);
    if (v > hi) begin
      sat_to32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat_to32 = 32'sh8000_0000;
    end else begin
      sat_to32 = v[31:0];
    end
  endfunction

endpackage

[rtl/linear_blend_skinning_2d_top.sv]
// Two-dimensional linear blend skinning in Q16.16. A load item writes one
// word (a, b, c, d, tx, ty) of a bone's affine transform; a weighted item
// adds its deform offset, transforms the position by its bone, scales by
// the weight and accumulates, emitting the saturated sum on its final
// influence and clearing it; an unweighted item transforms and emits at
// once. One item is in work at a time. A load is accepted and then does a
// read-modify-write of the bone row; a transform item passes through the
// registered bone table read, the two multiply steps of each lane, the
// rounding add and the translation, and a weighted item also through the
// weight multiply and the accumulate. An item that emits waits further
// while the result register still holds an untaken result.
// The bone table needs no initialization; reading a word never loaded
// gives an unspecified value.
module linear_blend_skinning_2d_top
  import lbs2d_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [5:0]         in_bone_index,
  input  logic [2:0]         in_coef_select,
  input  logic signed [31:0] in_coef_value,
  input  logic signed [31:0] in_vert_x,
  input  logic signed [31:0] in_vert_y,
  input  logic [16:0]        in_weight,
  input  logic signed [31:0] in_deform_x,
  input  logic signed [31:0] in_deform_y,
  input  logic               in_last_influence,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_world_x,
  output logic signed [31:0] out_world_y
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LOAD  = 4'd1;
  localparam logic [3:0] ST_MULA  = 4'd2;
  localparam logic [3:0] ST_MULB  = 4'd3;
  localparam logic [3:0] ST_SUM   = 4'd4;
  localparam logic [3:0] ST_XFORM = 4'd5;
  localparam logic [3:0] ST_WMUL  = 4'd6;
  localparam logic [3:0] ST_ACC   = 4'd7;
  localparam logic [3:0] ST_EMIT  = 4'd8;

  logic [3:0]               state_r, state_nxt;
  logic                     accept;
  logic                     in_oob;
  logic                     load_ok;

  logic                     wtd_r;
  logic                     last_r;
  logic                     oob_r;
  logic [2:0]               sel_r;
  logic signed [31:0]       coef_r;
  logic [BONE_AW-1:0]       bone_r;
  logic signed [31:0]       vx_r, vy_r;
  logic [16:0]              wgt_r;
  logic signed [63:0]       p_a_r, p_b_r, p_c_r, p_d_r;
  logic signed [64:0]       sum_x_r, sum_y_r;
  logic signed [31:0]       pos_x_r, pos_y_r;
  logic signed [SAT_W-1:0]  wm_x_r, wm_y_r;
  logic signed [31:0]       acc_x_r, acc_y_r;
  logic                     out_valid_r;
  logic signed [31:0]       out_x_r, out_y_r;

  logic [ROW_W-1:0]         rd_x, rd_y;
  logic [ROW_W-1:0]         wdata_x, wdata_y;
  logic                     we_x, we_y;
  logic signed [31:0]       coef_a, coef_b, coef_c, coef_d, coef_tx, coef_ty;
  logic signed [48:0]       sum_x_hi, sum_y_hi;
  logic signed [SAT_W-1:0]  wr_x, wr_y;
  logic signed [33:0]       wsh_x, wsh_y;
  logic                     out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_oob   = (BONE_CW'(in_bone_index) >= BONE_CW'(MAX_BONES));
  assign load_ok  = !in_oob && (in_coef_select <= COEF_TY);
  assign out_free = !out_valid_r || out_ready;

  // Bone table: x row holds {tx, b, a}, y row holds {ty, d, c}
  lbs2d_ram #(.WIDTH(ROW_W), .DEPTH(MAX_BONES)) u_mem_x (
    .clk   (clk),
    .we    (we_x),
    .waddr (bone_r),
    .wdata (wdata_x),
    .re    (accept),
    .raddr (BONE_AW'(in_bone_index)),
    .rdata (rd_x)
  );

  lbs2d_ram #(.WIDTH(ROW_W), .DEPTH(MAX_BONES)) u_mem_y (
    .clk   (clk),
    .we    (we_y),
    .waddr (bone_r),
    .wdata (wdata_y),
    .re    (accept),
    .raddr (BONE_AW'(in_bone_index)),
    .rdata (rd_y)
  );

  // Merge the loaded word into the row just read
  always_comb begin
    wdata_x = rd_x;
    wdata_y = rd_y;
    we_x    = 1'b0;
    we_y    = 1'b0;
    case (sel_r)
      COEF_A:  begin wdata_x[31:0]  = coef_r; we_x = 1'b1; end
      COEF_B:  begin wdata_x[63:32] = coef_r; we_x = 1'b1; end
      COEF_TX: begin wdata_x[95:64] = coef_r; we_x = 1'b1; end
      COEF_C:  begin wdata_y[31:0]  = coef_r; we_y = 1'b1; end
      COEF_D:  begin wdata_y[63:32] = coef_r; we_y = 1'b1; end
      COEF_TY: begin wdata_y[95:64] = coef_r; we_y = 1'b1; end
      default: begin we_x = 1'b0; we_y = 1'b0; end
    endcase
    if (state_r != ST_LOAD) begin
      we_x = 1'b0;
      we_y = 1'b0;
    end
  end

  // Out-of-range bones act as an all-zero transform
  assign coef_a  = oob_r ? 32'sd0 : rd_x[31:0];
  assign coef_b  = oob_r ? 32'sd0 : rd_x[63:32];
  assign coef_tx = oob_r ? 32'sd0 : rd_x[95:64];
  assign coef_c  = oob_r ? 32'sd0 : rd_y[31:0];
  assign coef_d  = oob_r ? 32'sd0 : rd_y[63:32];
  assign coef_ty = oob_r ? 32'sd0 : rd_y[95:64];

  assign sum_x_hi = sum_x_r[64:16];
  assign sum_y_hi = sum_y_r[64:16];

  // Round the weighted value half up, then drop the fraction
  assign wr_x  = wm_x_r + SAT_W'(32768);
  assign wr_y  = wm_y_r + SAT_W'(32768);
  assign wsh_x = wr_x[49:16];
  assign wsh_y = wr_y[49:16];

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_LOAD) begin
            state_nxt = load_ok ? ST_LOAD : ST_IDLE;
          end else if (in_kind == KIND_WEIGHTED || in_kind == KIND_UNWEIGHTED) begin
            state_nxt = ST_MULA;
          end
        end
      end
      ST_LOAD:  state_nxt = ST_IDLE;
      ST_MULA:  state_nxt = ST_MULB;
      ST_MULB:  state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_XFORM;
      ST_XFORM: state_nxt = wtd_r ? ST_WMUL : ST_EMIT;
      ST_WMUL:  state_nxt = ST_ACC;
      ST_ACC:   state_nxt = last_r ? ST_EMIT : ST_IDLE;
      ST_EMIT:  state_nxt = out_free ? ST_IDLE : ST_EMIT;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      acc_x_r     <= 32'sd0;
      acc_y_r     <= 32'sd0;
    end else begin
      state_r <= state_nxt;
      // Drop the result once taken, load a new one when free
      if (state_r == ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      // Accumulate, and clear once the sum has been emitted
      if (state_r == ST_ACC) begin
        acc_x_r <= sat_to32(SAT_W'(acc_x_r) + SAT_W'(wsh_x));
        acc_y_r <= sat_to32(SAT_W'(acc_y_r) + SAT_W'(wsh_y));
      end else if (state_r == ST_EMIT && out_free && wtd_r) begin
        acc_x_r <= 32'sd0;
        acc_y_r <= 32'sd0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    // Capture the item and apply the deform offset to a weighted one
    if (accept) begin
      wtd_r  <= (in_kind == KIND_WEIGHTED);
      last_r <= in_last_influence;
      oob_r  <= in_oob;
      sel_r  <= in_coef_select;
      coef_r <= in_coef_value;
      bone_r <= BONE_AW'(in_bone_index);
      wgt_r  <= in_weight;
      if (in_kind == KIND_WEIGHTED) begin
        vx_r <= sat_to32(SAT_W'(in_vert_x) + SAT_W'(in_deform_x));
        vy_r <= sat_to32(SAT_W'(in_vert_y) + SAT_W'(in_deform_y));
      end else begin
        vx_r <= in_vert_x;
        vy_r <= in_vert_y;
      end
    end
    // One multiply per lane per step
    if (state_r == ST_MULA) begin
      p_a_r <= vx_r * coef_a;
      p_c_r <= vx_r * coef_c;
    end
    if (state_r == ST_MULB) begin
      p_b_r <= vy_r * coef_b;
      p_d_r <= vy_r * coef_d;
    end
    // Exact sum plus the half-up rounding term
    if (state_r == ST_SUM) begin
      sum_x_r <= 65'(p_a_r) + 65'(p_b_r) + 65'(32768);
      sum_y_r <= 65'(p_c_r) + 65'(p_d_r) + 65'(32768);
    end
    // Add the translation and clamp
    if (state_r == ST_XFORM) begin
      pos_x_r <= sat_to32(SAT_W'(sum_x_hi) + SAT_W'(coef_tx));
      pos_y_r <= sat_to32(SAT_W'(sum_y_hi) + SAT_W'(coef_ty));
    end
    // Scale by the weight
    if (state_r == ST_WMUL) begin
      wm_x_r <= pos_x_r * $signed({1'b0, wgt_r});
      wm_y_r <= pos_y_r * $signed({1'b0, wgt_r});
    end
    // Hold the result until taken
    if (state_r == ST_EMIT && out_free) begin
      out_x_r <= wtd_r ? acc_x_r : pos_x_r;
      out_y_r <= wtd_r ? acc_y_r : pos_y_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_world_x = out_x_r;
  assign out_world_y = out_y_r;

endmodule

[rtl/lbs2d_ram.sv]
module lbs2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/lbs2d_checker.sv]
module lbs2d_checker
  import lbs2d_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         in_kind,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_world_x,
  input logic signed [31:0] out_world_y
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_world_x) && $stable(out_world_y))
    else $error("result changed while stalled");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A load item never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_LOAD && !out_valid |=> !out_valid)
    else $error("load item produced a result");

  // A transform item holds off new items in the cycle after it is taken
  a_xform_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == KIND_WEIGHTED || in_kind == KIND_UNWEIGHTED)
    |=> !in_ready)
    else $error("new item taken while a transform is in work");

endmodule

bind linear_blend_skinning_2d_top lbs2d_checker u_lbs2d_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_kind     (in_kind),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_world_x (out_world_x),
  .out_world_y (out_world_y)
);

[tb/tb.sv]
module tb;
  import lbs2d_pkg::*;

  localparam int WORDS_PER_BONE = 6;
  localparam int TABLE_WORDS    = MAX_BONES * WORDS_PER_BONE;
  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [2:0] COEF_SPARE_LO = 3'd6;
  localparam logic [2:0] COEF_SPARE_HI = 3'd7;
  localparam logic [16:0] WEIGHT_ONE = 17'd65536;
  localparam logic [16:0] WEIGHT_TOP = 17'd131071;
  localparam logic signed [31:0] Q_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] Q_HALF = 32'sh0000_8000;
  localparam int RANDOM_ITEMS = 850;
  localparam int DRAIN_CYCLES = 24;
  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_REPORTS  = 10;

  typedef logic signed [65:0] wide_t;

  typedef struct {
    logic [1:0]         kind;
    logic [5:0]         bone;
    logic [2:0]         sel;
    logic signed [31:0] coef;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [16:0]        weight;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic               last;
  } skin_item_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } world_pos_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_kind = '0;
  logic [5:0]         in_bone_index = '0;
  logic [2:0]         in_coef_select = '0;
  logic signed [31:0] in_coef_value = '0;
  logic signed [31:0] in_vert_x = '0;
  logic signed [31:0] in_vert_y = '0;
  logic [16:0]        in_weight = '0;
  logic signed [31:0] in_deform_x = '0;
  logic signed [31:0] in_deform_y = '0;
  logic               in_last_influence = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_world_x;
  logic signed [31:0] out_world_y;

  int idle_pct = 0;
  int stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // Shadow of the bone table and the blend accumulator
  logic signed [31:0] bone_word [TABLE_WORDS];
  bit                 word_loaded [TABLE_WORDS];
  logic signed [31:0] blend_x = '0;
  logic signed [31:0] blend_y = '0;
  world_pos_t         world_q [$];

  linear_blend_skinning_2d_top i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] clamp32(input wide_t v);
    if (v > wide_t'(Q_MAX)) begin
      return Q_MAX;
    end else if (v < wide_t'(Q_MIN)) begin
      return Q_MIN;
    end
    return v[31:0];
  endfunction

  // Apply a bone's affine transform, rounding half up before the translation
  function automatic world_pos_t transform_pos(input int bone, input logic signed [31:0] px,
                                               input logic signed [31:0] py);
    logic signed [31:0] m [WORDS_PER_BONE];
    wide_t sx;
    wide_t sy;
    world_pos_t r;
    for (int k = 0; k < WORDS_PER_BONE; k++) begin
      m[k] = (bone < MAX_BONES) ? bone_word[bone * WORDS_PER_BONE + k] : 32'sd0;
    end
    sx = (wide_t'(px) * wide_t'(m[COEF_A]) + wide_t'(py) * wide_t'(m[COEF_B])
          + wide_t'(32768)) >>> 16;
    sy = (wide_t'(px) * wide_t'(m[COEF_C]) + wide_t'(py) * wide_t'(m[COEF_D])
          + wide_t'(32768)) >>> 16;
    r.x = clamp32(sx + wide_t'(m[COEF_TX]));
    r.y = clamp32(sy + wide_t'(m[COEF_TY]));
    return r;
  endfunction

  // Scale by an unsigned Q1.16 weight, rounding half up
  function automatic wide_t weigh(input logic signed [31:0] v, input logic [16:0] w);
    return (wide_t'(v) * wide_t'({1'b0, w}) + wide_t'(32768)) >>> 16;
  endfunction

  // Advance the shadow state by one accepted item
  task automatic update_model(input skin_item_t it);
    world_pos_t t;
    int idx;
    logic signed [31:0] px;
    logic signed [31:0] py;
    case (it.kind)
      KIND_LOAD: begin
        if (int'(it.bone) < MAX_BONES && it.sel <= COEF_TY) begin
          idx = int'(it.bone) * WORDS_PER_BONE + int'(it.sel);
          bone_word[idx] = it.coef;
          word_loaded[idx] = 1'b1;
        end
      end
      KIND_WEIGHTED: begin
        px = clamp32(wide_t'(it.vx) + wide_t'(it.dx));
        py = clamp32(wide_t'(it.vy) + wide_t'(it.dy));
        t = transform_pos(int'(it.bone), px, py);
        blend_x = clamp32(wide_t'(blend_x) + weigh(t.x, it.weight));
        blend_y = clamp32(wide_t'(blend_y) + weigh(t.y, it.weight));
        if (it.last) begin
          world_q.push_back('{x: blend_x, y: blend_y});
          blend_x = '0;
          blend_y = '0;
        end
      end
      KIND_UNWEIGHTED: begin
        world_q.push_back(transform_pos(int'(it.bone), it.vx, it.vy));
      end
      default: ;
    endcase
  endtask

  function automatic bit bone_complete(input int b);
    for (int k = 0; k < WORDS_PER_BONE; k++) begin
      if (!word_loaded[b * WORDS_PER_BONE + k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Pick a bone whose six words are all loaded; bones 0 and 63 always are
  function automatic logic [5:0] pick_bone();
    logic [5:0] b;
    repeat (16) begin
      b = 6'($urandom_range(0, MAX_BONES - 1));
      if (bone_complete(int'(b))) return b;
    end
    return ($urandom_range(0, 1) != 0) ? 6'(MAX_BONES - 1) : 6'd0;
  endfunction

  // Mostly small Q16.16 values, some full range, some rails
  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(0, 9))
      0: return ($urandom_range(0, 1) != 0) ? Q_MAX : Q_MIN;
      1, 2: return $signed($urandom);
      default: return $signed(32'($urandom_range(0, 524287))) - 32'sd262144;
    endcase
  endfunction

  function automatic logic [16:0] rand_weight();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return WEIGHT_ONE;
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // Build a load item; fields it ignores are random
  function automatic skin_item_t make_load(input logic [5:0] bone, input logic [2:0] sel,
                                           input logic signed [31:0] value);
    skin_item_t it;
    it.kind   = KIND_LOAD;
    it.bone   = bone;
    it.sel    = sel;
    it.coef   = value;
    it.vx     = $signed($urandom);
    it.vy     = $signed($urandom);
    it.weight = 17'($urandom_range(0, 131071));
    it.dx     = $signed($urandom);
    it.dy     = $signed($urandom);
    it.last   = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Build a vertex item of any kind; the load fields are random
  function automatic skin_item_t make_vertex(input logic [1:0] kind, input logic [5:0] bone,
                                             input logic signed [31:0] vx,
                                             input logic signed [31:0] vy,
                                             input logic [16:0] weight,
                                             input logic signed [31:0] dx,
                                             input logic signed [31:0] dy,
                                             input logic last);
    skin_item_t it;
    it.kind   = kind;
    it.bone   = bone;
    it.sel    = 3'($urandom_range(0, 7));
    it.coef   = $signed($urandom);
    it.vx     = vx;
    it.vy     = vy;
    it.weight = weight;
    it.dx     = dx;
    it.dy     = dy;
    it.last   = last;
    return it;
  endfunction

  // Present one item, hold it until accepted, then update the shadow state
  task automatic send_item(input skin_item_t it);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_kind           <= it.kind;
    in_bone_index     <= it.bone;
    in_coef_select    <= it.sel;
    in_coef_value     <= it.coef;
    in_vert_x         <= it.vx;
    in_vert_y         <= it.vy;
    in_weight         <= it.weight;
    in_deform_x       <= it.dx;
    in_deform_y       <= it.dy;
    in_last_influence <= it.last;
    do @(posedge clk); while (!in_ready);
    update_model(it);
  endtask

  // Bone 0 scales, shears and translates; bone 63 sits on the rails
  task automatic test_bone_loads();
    send_item(make_load(6'd0, COEF_A, Q_ONE));
    send_item(make_load(6'd0, COEF_B, Q_HALF));
    send_item(make_load(6'd0, COEF_C, -Q_HALF));
    send_item(make_load(6'd0, COEF_D, Q_ONE));
    send_item(make_load(6'd0, COEF_TX, Q_ONE));
    send_item(make_load(6'd0, COEF_TY, -(Q_ONE + Q_ONE)));
    send_item(make_load(6'd63, COEF_A, Q_MIN));
    send_item(make_load(6'd63, COEF_B, Q_MIN));
    send_item(make_load(6'd63, COEF_C, Q_MAX));
    send_item(make_load(6'd63, COEF_D, Q_MIN));
    send_item(make_load(6'd63, COEF_TX, Q_MAX));
    send_item(make_load(6'd63, COEF_TY, Q_MIN));
  endtask

  // Largest products, exact half rounding both ways
  task automatic test_unweighted_extremes();
    send_item(make_vertex(KIND_UNWEIGHTED, 6'd63, Q_MIN, Q_MIN, WEIGHT_TOP, Q_MAX, Q_MAX, 1'b1));
    send_item(make_vertex(KIND_UNWEIGHTED, 6'd63, Q_MAX, 32'sd0, 17'd0, Q_MIN, Q_MIN, 1'b0));
    send_item(make_vertex(KIND_UNWEIGHTED, 6'd0, 32'sd1, 32'sd1, WEIGHT_ONE, '0, '0, 1'b1));
    send_item(make_vertex(KIND_UNWEIGHTED, 6'd0, -32'sd1, 32'sd0, 17'd0, '0, '0, 1'b0));
  endtask

  // Offset saturation, weights zero, one and above one, accumulator saturation
  task automatic test_weighted_blend();
    send_item(make_vertex(KIND_WEIGHTED, 6'd0, Q_MAX, Q_MIN, WEIGHT_ONE, Q_MAX, Q_MIN, 1'b0));
    send_item(make_vertex(KIND_WEIGHTED, 6'd63, Q_MIN, Q_MIN, WEIGHT_TOP, '0, '0, 1'b0));
    send_item(make_vertex(KIND_WEIGHTED, 6'd63, Q_MIN, Q_MIN, WEIGHT_TOP, '0, '0, 1'b0));
    send_item(make_vertex(KIND_WEIGHTED, 6'd0, Q_ONE, Q_ONE, 17'd0, '0, '0, 1'b1));
    send_item(make_vertex(KIND_WEIGHTED, 6'd0, -32'sd3, 32'sd5, 17'd32768,
                          -32'sd1, 32'sd1, 1'b1));
  endtask

  // Spare selectors and the unused kind change nothing
  task automatic test_ignored_items();
    send_item(make_load(6'd0, COEF_SPARE_LO, Q_MAX));
    send_item(make_load(6'd63, COEF_SPARE_HI, Q_MIN));
    send_item(make_vertex(KIND_NONE, 6'd0, Q_ONE, Q_ONE, WEIGHT_ONE, '0, '0, 1'b1));
    send_item(make_vertex(KIND_UNWEIGHTED, 6'd0, Q_ONE, Q_ONE, 17'd0, '0, '0, 1'b0));
  endtask

  // Mostly whole weighted vertices; some cut short, plus loads and noise
  task automatic test_random_skinning(input int n_items);
    int sent;
    int pick;
    int n_inf;
    logic [5:0] b;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        n_inf = $urandom_range(1, 4);
        for (int i = 0; i < n_inf; i++) begin
          send_item(make_vertex(KIND_WEIGHTED, pick_bone(), rand_q16(), rand_q16(),
                                rand_weight(),
                                ($urandom_range(0, 2) == 0) ? rand_q16() : 32'sd0,
                                ($urandom_range(0, 2) == 0) ? rand_q16() : 32'sd0,
                                (i == n_inf - 1) && ($urandom_range(0, 9) != 0)));
        end
        sent += n_inf;
      end else if (pick < 75) begin
        send_item(make_vertex(KIND_UNWEIGHTED, pick_bone(), rand_q16(), rand_q16(),
                              17'($urandom_range(0, 131071)), $signed($urandom),
                              $signed($urandom), 1'($urandom_range(0, 1))));
        sent++;
      end else if (pick < 83) begin
        b = 6'($urandom_range(0, MAX_BONES - 1));
        for (int k = 0; k < WORDS_PER_BONE; k++) begin
          send_item(make_load(b, 3'(k), rand_q16()));
        end
        sent += WORDS_PER_BONE;
      end else if (pick < 93) begin
        send_item(make_load(6'($urandom_range(0, MAX_BONES - 1)),
                            3'($urandom_range(0, 5)), rand_q16()));
        sent++;
      end else if ($urandom_range(0, 1) != 0) begin
        send_item(make_vertex(KIND_NONE, 6'($urandom_range(0, 63)), $signed($urandom),
                              $signed($urandom), 17'($urandom_range(0, 131071)),
                              $signed($urandom), $signed($urandom),
                              1'($urandom_range(0, 1))));
        sent++;
      end else begin
        send_item(make_load(6'($urandom_range(0, 63)),
                            ($urandom_range(0, 1) != 0) ? COEF_SPARE_HI : COEF_SPARE_LO,
                            $signed($urandom)));
        sent++;
      end
    end
  endtask

  // Stall the result side at the current rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Compare each result with the oldest expected world position
  always @(posedge clk) begin
    world_pos_t want;
    if (rst_n && out_valid && out_ready) begin
      if (world_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: world_x %0d world_y %0d", out_world_x, out_world_y);
      end else begin
        want = world_q.pop_front();
        if (want.x !== out_world_x || want.y !== out_world_y) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: world_x exp %0d got %0d, world_y exp %0d got %0d",
                     want.x, out_world_x, want.y, out_world_y);
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int idle_plan [4];
    int stall_plan [4];
    idle_plan  = '{0, 52, 0, 7};
    stall_plan = '{0, 0, 52, 7};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_bone_loads();
    test_unweighted_extremes();
    test_weighted_blend();
    test_ignored_items();

    // Random traffic through each idling and stalling phase
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_plan[p];
      stall_pct = stall_plan[p];
      test_random_skinning(RANDOM_ITEMS / 4);
    end
    in_valid <= 1'b0;

    // Drain outstanding results
    while (world_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && world_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/lbs2d_pkg.sv
rtl/lbs2d_ram.sv
rtl/linear_blend_skinning_2d_top.sv
rtl/lbs2d_checker.sv
tb/tb.sv
